// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the statement splitter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every clock edge outside reset
`define SQLSPLIT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// check that a condition holds in the cycle after a trigger
`define SQLSPLIT_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== hdl/sqlsplit_pkg.sv =====
// Types, constants and helpers shared by the statement splitter modules
package sqlsplit_pkg;

    localparam int SPACE_DEPTH_DEF = 32;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_OVF  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_LINE_C  = 3'd1,
        MODE_LINE_P  = 3'd2,
        MODE_BLOCK_C = 3'd3,
        MODE_BLOCK_P = 3'd4,
        MODE_SQUOTE  = 3'd5,
        MODE_DQUOTE  = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FLUSH_RD,
        ST_FLUSH_PUT,
        ST_EMITC,
        ST_END,
        ST_CLOSE
    } state_t;

    typedef enum logic [2:0] {
        SRC_WIN,
        SRC_ACT,
        SRC_BUF,
        SRC_END,
        SRC_OVF
    } src_t;

    typedef struct packed {
        logic in_ready;
        logic release_hold;
        logic apply;
        logic put_en;
        src_t put_src;
        logic set_started;
        logic clr_started;
        logic buf_wr;
        logic clear_space;
        logic flush_rd;
        logic flush_adv;
        logic reset_state;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic can_process;
        logic last;
        logic dec_emit;
        logic dec_end;
        logic c_ws;
        logic started;
        logic space_zero;
        logic space_full;
        logic act_end;
        logic slot_ok;
        logic flush_last;
    } status_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== hdl/sqlsplit_ctrl.sv =====
// Sequencing state machine of the statement splitter
`include "assert_macros.svh"

module sqlsplit_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sqlsplit_pkg::status_t sts,
    output sqlsplit_pkg::cmd_t    cmd
);
    import sqlsplit_pkg::*;

    state_t state_reg, state_next;
    logic   flush_case;
    logic   need_res;
    logic   end_ok;

    always_comb begin
        flush_case = sts.dec_emit && !sts.c_ws && !sts.space_zero;
        need_res   = sts.dec_emit && (!sts.c_ws || (sts.started && sts.space_full));
        end_ok     = !sts.started || sts.slot_ok;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (sts.in_valid && cmd.in_ready) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.can_process) begin
                    if (flush_case) begin
                        state_next = ST_FLUSH_RD;
                    end else if (!need_res || sts.slot_ok) begin
                        if (sts.dec_end) begin
                            state_next = ST_END;
                        end else if (sts.last) begin
                            state_next = ST_CHECK;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end else if (sts.last) begin
                    state_next = ST_CLOSE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH_RD: begin
                state_next = ST_FLUSH_PUT;
            end
            ST_FLUSH_PUT: begin
                if (sts.slot_ok) begin
                    state_next = sts.flush_last ? ST_EMITC : ST_FLUSH_RD;
                end
            end
            ST_EMITC: begin
                if (sts.slot_ok) begin
                    if (sts.act_end) begin
                        state_next = ST_END;
                    end else if (sts.last) begin
                        state_next = ST_CHECK;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_END: begin
                if (end_ok) begin
                    state_next = sts.last ? ST_CHECK : ST_IDLE;
                end
            end
            ST_CLOSE: begin
                if (end_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.put_src = SRC_WIN;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.in_ready     = !sts.slot_ok ? 1'b0 : 1'b1;
                cmd.release_hold = sts.slot_ok;
            end
            ST_CHECK: begin
                if (sts.can_process) begin
                    if (flush_case) begin
                        cmd.apply = 1'b1;
                    end else if (!need_res || sts.slot_ok) begin
                        cmd.apply = 1'b1;
                        if (sts.dec_emit) begin
                            if (!sts.c_ws) begin
                                cmd.put_en      = 1'b1;
                                cmd.put_src     = SRC_WIN;
                                cmd.set_started = 1'b1;
                            end else if (sts.started) begin
                                if (sts.space_full) begin
                                    cmd.put_en  = 1'b1;
                                    cmd.put_src = SRC_OVF;
                                end else begin
                                    cmd.buf_wr = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            ST_FLUSH_RD: begin
                cmd.flush_rd = 1'b1;
            end
            ST_FLUSH_PUT: begin
                if (sts.slot_ok) begin
                    cmd.put_en    = 1'b1;
                    cmd.put_src   = SRC_BUF;
                    cmd.flush_adv = 1'b1;
                end
            end
            ST_EMITC: begin
                if (sts.slot_ok) begin
                    cmd.put_en      = 1'b1;
                    cmd.put_src     = SRC_ACT;
                    cmd.set_started = 1'b1;
                    cmd.clear_space = 1'b1;
                end
            end
            ST_END: begin
                if (end_ok) begin
                    cmd.put_en      = sts.started;
                    cmd.put_src     = SRC_END;
                    cmd.clr_started = 1'b1;
                    cmd.clear_space = 1'b1;
                end
            end
            ST_CLOSE: begin
                if (end_ok) begin
                    cmd.put_en      = sts.started;
                    cmd.put_src     = SRC_END;
                    cmd.reset_state = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SQLSPLIT_ASSERT(a_flush_nonempty, (state_reg == ST_FLUSH_RD) |-> !sts.space_zero, "flush of empty buffer")
    `SQLSPLIT_ASSERT(a_close_on_last, (state_reg == ST_CLOSE) |-> sts.last, "close without end of source")
    `SQLSPLIT_ASSERT(a_apply_ready, cmd.apply |-> sts.can_process, "lexer step without lookahead")

endmodule

// ===== hdl/sqlsplit_dp.sv =====
// Lexer, lookahead window, whitespace buffer and output stage of the splitter
`include "assert_macros.svh"

module sqlsplit_dp #(
    parameter int SPACE_DEPTH = sqlsplit_pkg::SPACE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sqlsplit_pkg::cmd_t    cmd,
    output sqlsplit_pkg::status_t sts,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,  // in_byte
    input  logic                  s_tlast,  // end_of_source
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,  // out_byte
    output logic [1:0]            m_tuser,  // kind
    output logic                  m_tlast   // last_of_run
);
    import sqlsplit_pkg::*;

    localparam int AW = $clog2(SPACE_DEPTH);
    localparam int CW = $clog2(SPACE_DEPTH + 1);

    logic [7:0]    win_reg [3];
    logic [7:0]    win_next [3];
    logic [1:0]    win_count_reg, win_count_next;
    logic          last_reg, last_next;
    mode_t         mode_reg, mode_next;
    logic          skip_reg, skip_next;
    logic          started_reg, started_next;
    logic [CW-1:0] space_count_reg, space_count_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]    rd_data_reg;
    logic [7:0]    act_byte_reg, act_byte_next;
    logic          act_end_reg, act_end_next;
    logic [7:0]    space_mem [SPACE_DEPTH];

    logic          hold_valid_reg, hold_valid_next;
    logic [7:0]    hold_byte_reg, hold_byte_next;
    kind_t         hold_kind_reg, hold_kind_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [7:0]    m_tdata_reg, m_tdata_next;
    kind_t         m_kind_reg, m_kind_next;
    logic          m_tlast_reg, m_tlast_next;

    logic          accept;
    logic          out_free;
    logic          slot_ok;
    logic [7:0]    c, n1, n2;
    logic          h1, h2;
    logic          dec_emit, dec_end;
    mode_t         dec_mode;
    logic          dec_skip;
    logic [7:0]    new_byte;
    kind_t         new_kind;

    assign accept   = s_tvalid && cmd.in_ready;
    assign s_tready = cmd.in_ready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign slot_ok  = !hold_valid_reg || out_free;

    assign c  = win_reg[0];
    assign n1 = win_reg[1];
    assign n2 = win_reg[2];
    assign h1 = (win_count_reg >= 2'd2);
    assign h2 = (win_count_reg == 2'd3);

    always_comb begin
        dec_emit = 1'b0;
        dec_end  = 1'b0;
        dec_mode = mode_reg;
        dec_skip = 1'b0;
        if (skip_reg) begin
            case (mode_reg)
                MODE_SQUOTE, MODE_DQUOTE: begin
                    dec_emit = 1'b1;
                end
                MODE_BLOCK_C, MODE_BLOCK_P: begin
                    dec_emit = (mode_reg == MODE_BLOCK_P);
                    if (c == CH_SLASH) begin
                        dec_mode = MODE_NORMAL;
                    end
                end
                default: dec_emit = 1'b0;
            endcase
        end else begin
            case (mode_reg)
                MODE_LINE_C: begin
                    if (c == CH_LF) begin
                        dec_emit = 1'b1;
                        dec_mode = MODE_NORMAL;
                    end
                end
                MODE_LINE_P: begin
                    dec_emit = 1'b1;
                    if (c == CH_LF) begin
                        dec_mode = MODE_NORMAL;
                    end
                end
                MODE_BLOCK_C, MODE_BLOCK_P: begin
                    dec_emit = (mode_reg == MODE_BLOCK_P);
                    dec_skip = (c == CH_STAR) && h1 && (n1 == CH_SLASH);
                end
                MODE_SQUOTE, MODE_DQUOTE: begin
                    dec_emit = 1'b1;
                    if (c == CH_BSLASH) begin
                        dec_skip = 1'b1;
                    end else if (c == ((mode_reg == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE)) begin
                        dec_mode = MODE_NORMAL;
                    end
                end
                default: begin
                    if ((c == CH_SLASH) && h1 && (n1 == CH_STAR)) begin
                        if (h2 && ((n2 == CH_PLUS) || (n2 == CH_BANG))) begin
                            dec_mode = MODE_BLOCK_P;
                            dec_emit = 1'b1;
                        end else begin
                            dec_mode = MODE_BLOCK_C;
                            dec_skip = 1'b1;
                        end
                    end else if ((c == CH_DASH) && h1 && (n1 == CH_DASH)) begin
                        if (h2 && ((n2 == CH_PLUS) || (n2 == CH_BANG))) begin
                            dec_mode = MODE_LINE_P;
                            dec_emit = 1'b1;
                        end else begin
                            dec_mode = MODE_LINE_C;
                        end
                    end else if (c == CH_SQUOTE) begin
                        dec_mode = MODE_SQUOTE;
                        dec_emit = 1'b1;
                    end else if (c == CH_DQUOTE) begin
                        dec_mode = MODE_DQUOTE;
                        dec_emit = 1'b1;
                    end else if (c == CH_SEMI) begin
                        dec_end = 1'b1;
                    end else if ((c == CH_COLON) && h1 && is_ws(n1)) begin
                        dec_emit = 1'b1;
                        dec_end  = 1'b1;
                        dec_skip = 1'b1;
                    end else begin
                        dec_emit = 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb begin
        sts.in_valid    = s_tvalid;
        sts.can_process = h2 || (last_reg && (win_count_reg != 2'd0));
        sts.last        = last_reg;
        sts.dec_emit    = dec_emit;
        sts.dec_end     = dec_end;
        sts.c_ws        = is_ws(c);
        sts.started     = started_reg;
        sts.space_zero  = (space_count_reg == '0);
        sts.space_full  = (space_count_reg == CW'(SPACE_DEPTH));
        sts.act_end     = act_end_reg;
        sts.slot_ok     = slot_ok;
        sts.flush_last  = ((CW'(rd_idx_reg) + CW'(1)) == space_count_reg);
    end

    always_comb begin
        win_next         = win_reg;
        win_count_next   = win_count_reg;
        last_next        = last_reg;
        mode_next        = mode_reg;
        skip_next        = skip_reg;
        started_next     = started_reg;
        space_count_next = space_count_reg;
        rd_idx_next      = rd_idx_reg;
        act_byte_next    = act_byte_reg;
        act_end_next     = act_end_reg;
        if (accept) begin
            win_next[win_count_reg] = s_tdata;
            win_count_next          = win_count_reg + 2'd1;
            last_next               = s_tlast;
        end
        if (cmd.apply) begin
            win_next[0]    = win_reg[1];
            win_next[1]    = win_reg[2];
            win_count_next = win_count_reg - 2'd1;
            mode_next      = dec_mode;
            skip_next      = dec_skip;
            act_byte_next  = c;
            act_end_next   = dec_end;
            rd_idx_next    = '0;
        end
        if (cmd.buf_wr) begin
            space_count_next = space_count_reg + CW'(1);
        end
        if (cmd.flush_adv) begin
            rd_idx_next = rd_idx_reg + AW'(1);
        end
        if (cmd.set_started) begin
            started_next     = 1'b1;
            space_count_next = '0;
        end
        if (cmd.clr_started) begin
            started_next = 1'b0;
        end
        if (cmd.clear_space) begin
            space_count_next = '0;
        end
        if (cmd.reset_state) begin
            win_count_next   = '0;
            last_next        = 1'b0;
            mode_next        = MODE_NORMAL;
            skip_next        = 1'b0;
            started_next     = 1'b0;
            space_count_next = '0;
        end
    end

    always_comb begin
        new_byte = 8'd0;
        new_kind = KIND_BYTE;
        case (cmd.put_src)
            SRC_WIN: new_byte = c;
            SRC_ACT: new_byte = act_byte_reg;
            SRC_BUF: new_byte = rd_data_reg;
            SRC_END: new_kind = KIND_END;
            SRC_OVF: new_kind = KIND_OVF;
            default: new_byte = 8'd0;
        endcase
    end

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        hold_kind_next  = hold_kind_reg;
        m_tdata_next    = m_tdata_reg;
        m_kind_next     = m_kind_reg;
        m_tlast_next    = m_tlast_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        if (cmd.put_en) begin
            if (hold_valid_reg) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = hold_byte_reg;
                m_kind_next   = hold_kind_reg;
                m_tlast_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_byte_next  = new_byte;
            hold_kind_next  = new_kind;
        end else if (cmd.release_hold && hold_valid_reg) begin
            m_tvalid_next   = 1'b1;
            m_tdata_next    = hold_byte_reg;
            m_kind_next     = hold_kind_reg;
            m_tlast_next    = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.buf_wr) begin
            space_mem[space_count_reg[AW-1:0]] <= c;
        end
        if (cmd.flush_rd) begin
            rd_data_reg <= space_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        win_reg       <= win_next;
        rd_idx_reg    <= rd_idx_next;
        act_byte_reg  <= act_byte_next;
        act_end_reg   <= act_end_next;
        hold_byte_reg <= hold_byte_next;
        hold_kind_reg <= hold_kind_next;
        m_tdata_reg   <= m_tdata_next;
        m_kind_reg    <= m_kind_next;
        m_tlast_reg   <= m_tlast_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_count_reg   <= '0;
            last_reg        <= 1'b0;
            mode_reg        <= MODE_NORMAL;
            skip_reg        <= 1'b0;
            started_reg     <= 1'b0;
            space_count_reg <= '0;
            hold_valid_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            win_count_reg   <= win_count_next;
            last_reg        <= last_next;
            mode_reg        <= mode_next;
            skip_reg        <= skip_next;
            started_reg     <= started_next;
            space_count_reg <= space_count_next;
            hold_valid_reg  <= hold_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_tlast_reg;

    `SQLSPLIT_ASSERT(a_win_room, accept |-> (win_count_reg != 2'd3), "item accepted into full window")
    `SQLSPLIT_ASSERT(a_space_bound, space_count_reg <= CW'(SPACE_DEPTH), "whitespace count past depth")
    `SQLSPLIT_ASSERT(a_put_slot, cmd.put_en |-> slot_ok, "result produced without a free slot")
    `SQLSPLIT_ASSERT_NEXT(a_hold_kept, hold_valid_reg && !out_free, hold_valid_reg, "held result lost")

endmodule

// ===== hdl/sql_statement_splitter_top.sv =====
// A result waits in a hold register and moves to the m_tvalid register when the next result
// is made, or with last_of_run set when released in IDLE. Per byte: accept in IDLE, then a lexer
// step in CHECK with at most one result; bytes are accepted only in IDLE, and puts wait for a
// free output slot. Each flushed space takes a registered read and a put, then the byte after
// them is put; END follows an end of statement; at end_of_source all bytes step, then CLOSE.
// Reset: synchronous active-low aresetn; the whitespace buffer gets no clearing pass.
module sql_statement_splitter_top #(
    parameter int SPACE_DEPTH = sqlsplit_pkg::SPACE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // end_of_source
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [1:0] m_tuser,   // kind
    output logic       m_tlast    // last_of_run
);
    import sqlsplit_pkg::*;

    cmd_t    cmd;
    status_t sts;

    sqlsplit_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    sqlsplit_dp #(
        .SPACE_DEPTH (SPACE_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/sql_statement_splitter_top_test.sv =====
// Testbench for the SQL statement splitter: directed and random scripts checked against a predictor
import sqlsplit_pkg::*;

class statement_checker;
    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } result_t;

    result_t    pending_results[$];
    result_t    step_results[$];
    int         errors;
    mode_t      mode;
    logic [7:0] lookahead[2];
    int         lookahead_n;
    bit         skip_next;
    bit         started;
    logic [7:0] held_spaces[SPACE_DEPTH_DEF];
    int         held_n;

    function new();
        errors = 0;
        clear_state();
    endfunction

    function void clear_state();
        mode = MODE_NORMAL;
        lookahead[0] = 8'h00;
        lookahead[1] = 8'h00;
        lookahead_n = 0;
        skip_next = 1'b0;
        started = 1'b0;
        held_n = 0;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    function bit is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function void put(logic [7:0] d, kind_t k);
        result_t r;
        if (step_results.size() >= SPACE_DEPTH_DEF + 4) return;
        r.data = d;
        r.kind = k;
        r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    function void emit(logic [7:0] c);
        if (is_blank(c)) begin
            if (!started) return;
            if (held_n < SPACE_DEPTH_DEF) begin
                held_spaces[held_n] = c;
                held_n++;
            end else begin
                put(8'h00, KIND_OVF);
            end
            return;
        end
        started = 1'b1;
        for (int i = 0; i < held_n; i++) put(held_spaces[i], KIND_BYTE);
        held_n = 0;
        put(c, KIND_BYTE);
    endfunction

    function void end_statement();
        if (started) put(8'h00, KIND_END);
        started = 1'b0;
        held_n = 0;
    endfunction

    function void lex_step(logic [7:0] c, bit h1, logic [7:0] n1, bit h2, logic [7:0] n2);
        mode_t m;
        m = mode;
        if (skip_next) begin
            skip_next = 1'b0;
            if (m == MODE_SQUOTE || m == MODE_DQUOTE) begin
                emit(c);
            end else if (m == MODE_BLOCK_C || m == MODE_BLOCK_P) begin
                if (m == MODE_BLOCK_P) emit(c);
                if (c == CH_SLASH) mode = MODE_NORMAL;
            end
            return;
        end
        case (m)
            MODE_LINE_C: begin
                if (c == CH_LF) begin
                    emit(c);
                    mode = MODE_NORMAL;
                end
                return;
            end
            MODE_LINE_P: begin
                emit(c);
                if (c == CH_LF) mode = MODE_NORMAL;
                return;
            end
            MODE_BLOCK_C, MODE_BLOCK_P: begin
                if (m == MODE_BLOCK_P) emit(c);
                if (c == CH_STAR && h1 && n1 == CH_SLASH) skip_next = 1'b1;
                return;
            end
            MODE_SQUOTE, MODE_DQUOTE: begin
                emit(c);
                if (c == CH_BSLASH) skip_next = 1'b1;
                else if (c == ((m == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE)) mode = MODE_NORMAL;
                return;
            end
            default: ;
        endcase
        if (c == CH_SLASH && h1 && n1 == CH_STAR) begin
            if (h2 && (n2 == CH_PLUS || n2 == CH_BANG)) begin
                mode = MODE_BLOCK_P;
                emit(c);
            end else begin
                mode = MODE_BLOCK_C;
                skip_next = 1'b1;
            end
        end else if (c == CH_DASH && h1 && n1 == CH_DASH) begin
            if (h2 && (n2 == CH_PLUS || n2 == CH_BANG)) begin
                mode = MODE_LINE_P;
                emit(c);
            end else begin
                mode = MODE_LINE_C;
            end
        end else if (c == CH_SQUOTE) begin
            mode = MODE_SQUOTE;
            emit(c);
        end else if (c == CH_DQUOTE) begin
            mode = MODE_DQUOTE;
            emit(c);
        end else if (c == CH_SEMI) begin
            end_statement();
        end else if (c == CH_COLON && h1 && is_blank(n1)) begin
            emit(c);
            end_statement();
            skip_next = 1'b1;
        end else begin
            emit(c);
        end
    endfunction

    function void take_script_byte(logic [7:0] c, logic last);
        logic [7:0] seq[4];
        int         n;
        result_t    tail;
        step_results.delete();
        seq[3] = 8'h00;
        for (int i = 0; i < lookahead_n; i++) seq[i] = lookahead[i];
        seq[lookahead_n] = c;
        n = lookahead_n + 1;
        if (!last) begin
            if (n == 3) begin
                lex_step(seq[0], 1'b1, seq[1], 1'b1, seq[2]);
                lookahead[0] = seq[1];
                lookahead[1] = seq[2];
                lookahead_n = 2;
            end else begin
                for (int i = 0; i < n; i++) lookahead[i] = seq[i];
                lookahead_n = n;
            end
        end else begin
            for (int i = 0; i < n; i++) begin
                lex_step(seq[i], i + 1 < n, (i + 1 < n) ? seq[i + 1] : 8'h00,
                         i + 2 < n, (i + 2 < n) ? seq[i + 2] : 8'h00);
            end
            end_statement();
            clear_state();
        end
        if (step_results.size() > 0) begin
            tail = step_results.pop_back();
            tail.last = 1'b1;
            step_results.push_back(tail);
        end
        foreach (step_results[i]) pending_results.push_back(step_results[i]);
    endfunction

    function void check_output(logic [7:0] data, logic [1:0] kind, logic last);
        result_t want;
        if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result out_byte=%02h kind=%0d last=%0b",
                     $time, data, kind, last);
            return;
        end
        want = pending_results.pop_front();
        if (data !== want.data) begin
            errors++;
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
        end
        if (kind !== want.kind) begin
            errors++;
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
        end
        if (last !== want.last) begin
            errors++;
            $display("%0t: last_of_run expected %0b actual %0b", $time, want.last, last);
        end
    endfunction
endclass

module sql_statement_splitter_top_test;
    localparam int CYCLE_LIMIT = 500000;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // in_byte
    logic       s_tlast;    // end_of_source
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // out_byte
    logic [1:0] m_tuser;    // kind
    logic       m_tlast;    // last_of_run

    statement_checker stmt_check = new();
    logic [7:0]       script[$];
    int               bytes_sent = 0;
    int               cycles = 0;
    bit               in_burst = 1'b0;
    bit               out_burst = 1'b0;

    sql_statement_splitter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 8);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        stmt_check.take_script_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_script();
        foreach (script[i]) send_byte(script[i], i == script.size() - 1);
        script.delete();
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) script.push_back(s[i]);
        send_script();
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tlast = 1'b0;
        while (stmt_check.pending() != 0) @(negedge aclk);
    endtask

    task automatic add_text(int n);
        string specials = "*/\\'\"-;:\n ";
        repeat (n) begin
            if ($urandom_range(0, 9) < 7) script.push_back(8'("a" + $urandom_range(0, 25)));
            else script.push_back(specials[$urandom_range(0, specials.len() - 1)]);
        end
    endtask

    task automatic add_token();
        int n;
        case ($urandom_range(0, 15))
            0, 1, 2: begin
                n = $urandom_range(1, 6);
                repeat (n) script.push_back(8'("a" + $urandom_range(0, 25)));
            end
            3, 4: begin
                n = ($urandom_range(0, 10) == 0) ? $urandom_range(33, 45) : $urandom_range(1, 4);
                repeat (n) script.push_back(blank_char());
            end
            5: script.push_back(CH_SEMI);
            6: begin
                script.push_back(CH_COLON);
                script.push_back(blank_char());
            end
            7: begin
                script.push_back(CH_DASH);
                script.push_back(CH_DASH);
                add_text($urandom_range(0, 6));
                script.push_back(CH_LF);
            end
            8: begin
                script.push_back(CH_DASH);
                script.push_back(CH_DASH);
                script.push_back($urandom_range(0, 1) ? CH_PLUS : CH_BANG);
                add_text($urandom_range(0, 6));
                script.push_back(CH_LF);
            end
            9: begin
                script.push_back(CH_SLASH);
                script.push_back(CH_STAR);
                add_text($urandom_range(0, 6));
                script.push_back(CH_STAR);
                script.push_back(CH_SLASH);
                if ($urandom_range(0, 1)) script.push_back($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
            end
            10: begin
                script.push_back(CH_SLASH);
                script.push_back(CH_STAR);
                script.push_back($urandom_range(0, 1) ? CH_PLUS : CH_BANG);
                add_text($urandom_range(0, 6));
                script.push_back(CH_STAR);
                script.push_back(CH_SLASH);
            end
            11: begin
                script.push_back(CH_SQUOTE);
                add_text($urandom_range(0, 6));
                script.push_back(CH_SQUOTE);
            end
            12: begin
                script.push_back(CH_DQUOTE);
                add_text($urandom_range(0, 6));
                script.push_back(CH_DQUOTE);
            end
            13: script.push_back(8'($urandom_range(0, 255)));
            14: begin
                script.push_back(CH_COLON);
                script.push_back(8'("a" + $urandom_range(0, 25)));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: script.push_back(CH_DASH);
                    1: script.push_back(CH_SLASH);
                    2: script.push_back(CH_STAR);
                    default: script.push_back(CH_BSLASH);
                endcase
            end
        endcase
    endtask

    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            gap = out_burst ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            stmt_check.check_output(m_tdata, m_tuser, m_tlast);
            if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
        end
    end

    initial begin
        int n;
        int cut;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_text("a/*/*/*b;");
        send_text("--+\n'\\''x:\t");
        send_text("\"\"--\n/*+");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        while (bytes_sent < 300) begin
            n = $urandom_range(1, 14);
            repeat (n) add_token();
            if ($urandom_range(0, 7) == 0) begin
                cut = $urandom_range(1, script.size());
                while (script.size() > cut) void'(script.pop_back());
            end
            if ($urandom_range(0, 3) == 0) in_burst = !in_burst;
            send_script();
            if ($urandom_range(0, 5) == 0) drain();
        end

        drain();
        repeat (20) @(posedge aclk);
        if (stmt_check.errors == 0 && stmt_check.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
